// ===== hdl/wbps_pkg.sv =====
// wbps_pkg: shared types and constants of the wildcard byte pattern scanner
// no dependencies; used by every file under hdl

package wbps_pkg;

	localparam int SIG_BYTES = 32;
	localparam int SIG_IDX_W = 5;
	localparam int LEN_W     = 6;
	localparam int POS_W     = 32;
	localparam int ADDR_W    = 6;
	localparam int DATA_W    = 64;
	localparam int CARE_W    = 32;

	localparam logic [POS_W-1:0] POS_MAX = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		REG_PAT0 = 3'd0,
		REG_PAT1 = 3'd1,
		REG_PAT2 = 3'd2,
		REG_PAT3 = 3'd3,
		REG_CARE = 3'd4,
		REG_LEN  = 3'd5
	} reg_idx_t;

	typedef logic [SIG_BYTES-1:0][7:0] sig_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_end;
	} in_word_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] match_offset;
	} out_word_t;

	typedef struct packed {
		logic             shift;
		logic [LEN_W-1:0] len;
	} cell_ctl_t;

endpackage

// ===== hdl/wbps_cell.sv =====
// wbps_cell: one window cell, holds a stream byte and checks it against its signature byte
// depends on wbps_pkg

module wbps_cell #(
	parameter int POS = 0
) (
	input  logic                 clk,
	input  wbps_pkg::cell_ctl_t  ctl,
	input  logic [7:0]           byte_in,
	input  wbps_pkg::sig_t       sig,
	input  logic [31:0]          care,
	output logic [7:0]           byte_out,
	output logic                 ok
);
	import wbps_pkg::*;

	logic [7:0]       byte_q;
	logic [LEN_W-1:0] k_full;
	logic [SIG_IDX_W-1:0] k;
	logic             in_use;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= byte_in;
		end
	end

	// window entry POS pairs with signature byte len-1-POS
	assign k_full   = ctl.len - LEN_W'(1) - LEN_W'(POS);
	assign k        = k_full[SIG_IDX_W-1:0];
	assign in_use   = LEN_W'(POS) < ctl.len;
	assign ok       = !in_use || !care[k] || (byte_q == sig[k]);
	assign byte_out = byte_q;

endmodule

// ===== hdl/wildcard_byte_pattern_scanner_unit.sv =====
// wildcard_byte_pattern_scanner_unit: top level, register port, cell row and result register
// depends on wbps_pkg and wbps_cell
//
// channel   dir  handshake             word
// byte      in   byte_valid/byte_ready  wbps_pkg::in_word_t  (data_byte, region_end)
// res       out  res_valid/res_ready    wbps_pkg::out_word_t (found, match_offset)
// cfg       in   apb psel/penable       64-bit registers at 8*index
//
// one byte per cycle while byte_ready holds; the cell row shifts on every accepted word
// a compare-stage result is written to the output register once it is empty or being read
// byte_ready drops only while a compare with a result waits on a full output register
// arst_n clears control state; no clearing pass is needed after reset

module wildcard_byte_pattern_scanner_unit #(
	parameter int MAX_PATTERN_BYTES = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        byte_valid,
	output logic                        byte_ready,
	input  wbps_pkg::in_word_t          byte_word,
	output logic                        res_valid,
	input  logic                        res_ready,
	output wbps_pkg::out_word_t         res_word,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wbps_pkg::ADDR_W-1:0] paddr,
	input  logic [wbps_pkg::DATA_W-1:0] pwdata,
	output logic [wbps_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import wbps_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

	logic [DATA_W-1:0] pat_q [4];
	logic [CARE_W-1:0] care_q;
	logic [LEN_W-1:0]  len_q;
	logic              wr_en;
	reg_idx_t          reg_idx;

	sig_t              sig;
	logic [LEN_W-1:0]  len_eff;
	cell_ctl_t         ctl;

	logic [7:0]        win [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] ok_vec;

	logic              valid_s1;
	logic              last_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              matched_q;
	logic              res_valid_q;
	out_word_t         res_word_q;

	logic              accept;
	logic              hit;
	logic              s1_res;
	logic              s1_go;
	logic [POS_W-1:0]  pos_base;
	logic [POS_W-1:0]  pos_next;

	// register port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				pat_q[i] <= '0;
			end
			care_q <= '0;
			len_q  <= LEN_W'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_PAT0: pat_q[0] <= pwdata;
				REG_PAT1: pat_q[1] <= pwdata;
				REG_PAT2: pat_q[2] <= pwdata;
				REG_PAT3: pat_q[3] <= pwdata;
				REG_CARE: care_q   <= pwdata[CARE_W-1:0];
				REG_LEN:  len_q    <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_PAT0: prdata = pat_q[0];
			REG_PAT1: prdata = pat_q[1];
			REG_PAT2: prdata = pat_q[2];
			REG_PAT3: prdata = pat_q[3];
			REG_CARE: prdata = DATA_W'(care_q);
			REG_LEN:  prdata = DATA_W'(len_q);
			default:  prdata = '0;
		endcase
	end

	assign sig = {pat_q[3], pat_q[2], pat_q[1], pat_q[0]};

	always_comb begin
		if (len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (len_q > MAX_LEN) begin
			len_eff = MAX_LEN;
		end else begin
			len_eff = len_q;
		end
	end

	// cell row
	assign ctl.shift = accept;
	assign ctl.len   = len_eff;

	for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
		logic [7:0] feed;
		if (j == 0) begin : g_head
			assign feed = byte_word.data_byte;
		end else begin : g_link
			assign feed = win[j-1];
		end
		wbps_cell #(
			.POS(j)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.byte_in  (feed),
			.sig      (sig),
			.care     (care_q),
			.byte_out (win[j]),
			.ok       (ok_vec[j])
		);
	end

	// compare stage
	assign hit      = !matched_q && (pos_s1 >= POS_W'(len_eff)) && (&ok_vec);
	assign s1_res   = valid_s1 && (hit || (last_s1 && !matched_q));
	assign s1_go    = valid_s1 && (!s1_res || !res_valid_q || res_ready);
	assign byte_ready = !valid_s1 || s1_go;
	assign accept   = byte_valid && byte_ready;

	assign pos_base = last_s1 ? '0 : pos_s1;
	assign pos_next = (pos_base == POS_MAX) ? POS_MAX : pos_base + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			last_s1   <= 1'b0;
			pos_s1    <= '0;
			matched_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				last_s1  <= byte_word.region_end;
				pos_s1   <= pos_next;
			end else if (s1_go) begin
				valid_s1 <= 1'b0;
			end
			if (s1_go) begin
				matched_q <= last_s1 ? 1'b0 : (matched_q || hit);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_go && s1_res) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_res) begin
			res_word_q.found        <= hit;
			res_word_q.match_offset <= hit ? (pos_s1 - POS_W'(len_eff)) : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule

// ===== hdl/wbps_checker.sv =====
// wbps_checker: port-level assertions for the scanner, bound to the top level
// depends on wbps_pkg and wildcard_byte_pattern_scanner_unit

module wbps_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        byte_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input wbps_pkg::out_word_t         res_word,
	input logic                        psel,
	input logic                        penable,
	input logic                        pready
);

	// a held result word does not change
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_word))
		else $error("result word changed while stalled");

	// a no-match word carries offset zero
	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_word.found |-> res_word.match_offset == '0)
		else $error("no-match word with nonzero offset");

	// input stalls only under output back-pressure
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!byte_ready |-> res_valid && !res_ready)
		else $error("input stalled without output back-pressure");

	// register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable |-> pready)
		else $error("pready low in access cycle");

endmodule

bind wildcard_byte_pattern_scanner_unit wbps_checker u_wbps_checker (.*);

// ===== tb/sv/tb_wildcard_byte_pattern_scanner_unit.sv =====
// tb_wildcard_byte_pattern_scanner_unit: self-checking testbench for the wildcard byte pattern scanner
// drives byte words and apb register writes, predicts found/match_offset words and checks them
// depends on wbps_pkg and wildcard_byte_pattern_scanner_unit
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_scanner_unit;

	import wbps_pkg::*;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                byte_valid = 1'b0;
	logic                byte_ready;
	in_word_t            byte_word = '0;
	logic                res_valid;
	logic                res_ready = 1'b0;
	out_word_t           res_word;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [ADDR_W-1:0]   paddr = '0;
	logic [DATA_W-1:0]   pwdata = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	// register copies
	sig_t                sig_cfg = '0;
	logic [CARE_W-1:0]   care_cfg = '0;
	logic [LEN_W-1:0]    len_cfg = 6'd1;

	// scan state
	sig_t                win = '0;
	logic [POS_W-1:0]    pos = '0;
	logic                reported = 1'b0;

	in_word_t            pending_bytes[$];
	out_word_t           expected_reports[$];

	int                  byte_sent = 0;
	int                  byte_taken = 0;
	int                  byte_wait = 0;
	int                  byte_gap_max = 8;
	int                  res_taken = 0;
	int                  res_seen = 0;
	int                  res_wait = 0;
	int                  res_stall_max = 8;
	int                  n_err = 0;

	wildcard_byte_pattern_scanner_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_word  (byte_word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_word   (res_word),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("tb_wildcard_byte_pattern_scanner_unit: errors");
		$finish;
	end

	function automatic int eff_len();
		if (len_cfg == 0)
			return 1;
		if (len_cfg > SIG_BYTES)
			return SIG_BYTES;
		return int'(len_cfg);
	endfunction

	task automatic predict_scan(input in_word_t w);
		int n;
		int k;
		logic hit;
		n = eff_len();
		win = {win[SIG_BYTES-2:0], w.data_byte};
		if (pos != POS_MAX)
			pos = pos + 1;
		hit = 1'b1;
		for (k = 0; k < n; k++)
			if (care_cfg[k] && win[n-1-k] != sig_cfg[k])
				hit = 1'b0;
		if (!reported && pos >= n && hit) begin
			reported = 1'b1;
			expected_reports.insert(expected_reports.size(),
				out_word_t'{found: 1'b1, match_offset: pos - 32'(n)});
		end
		if (w.region_end) begin
			if (!reported)
				expected_reports.insert(expected_reports.size(),
					out_word_t'{found: 1'b0, match_offset: '0});
			win = '0;
			pos = '0;
			reported = 1'b0;
		end
	endtask

	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] v);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (idx)
			REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: sig_cfg[int'(idx)*8 +: 8] = v;
			REG_CARE: care_cfg = v[CARE_W-1:0];
			REG_LEN: len_cfg = v[LEN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b, input logic last);
		pending_bytes.insert(pending_bytes.size(), in_word_t'{data_byte: b, region_end: last});
	endtask

	task automatic drain();
		while (pending_bytes.size() != 0 || byte_sent != byte_taken
				|| expected_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// byte driver
	always @(negedge clk) begin
		if (byte_sent == byte_taken) begin
			if (byte_wait > 0) begin
				byte_wait--;
				byte_valid <= 1'b0;
			end else if (pending_bytes.size() != 0) begin
				byte_word <= pending_bytes.pop_front();
				byte_valid <= 1'b1;
				byte_sent++;
				byte_wait = $urandom_range(0, byte_gap_max);
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// result ready driver
	always @(negedge clk) begin
		if (res_seen != res_taken) begin
			res_seen = res_taken;
			res_wait = $urandom_range(0, res_stall_max);
		end
		if (res_wait > 0) begin
			res_wait--;
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		out_word_t want;
		if (arst_n) begin
			if (byte_valid && byte_ready) begin
				predict_scan(byte_word);
				byte_taken <= byte_taken + 1;
			end
			if (res_valid && res_ready) begin
				res_taken <= res_taken + 1;
				if (expected_reports.size() == 0) begin
					$error("res word with nothing expected: found %0d match_offset %0h",
						res_word.found, res_word.match_offset);
					n_err++;
				end else begin
					want = expected_reports.pop_front();
					if (res_word.found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, res_word.found);
						n_err++;
					end
					if (res_word.match_offset !== want.match_offset) begin
						$error("match_offset: expected %0h, got %0h",
							want.match_offset, res_word.match_offset);
						n_err++;
					end
				end
			end
		end
	end

	initial begin : stim
		int ph;
		int total;
		int rl;
		int at;
		int k;
		int n;
		int mode;
		logic close;
		logic [7:0] rb [0:63];
		logic [63:0] w;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: one wildcard byte, every byte matches
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'hAA, 1'b1);
		drain();

		apb_write(REG_PAT0, 64'h0000_0000_EFBE_ADDE);
		apb_write(REG_PAT1, 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(REG_PAT2, 64'h0);
		apb_write(REG_PAT3, 64'hFFFF_FFFF_FFFF_FFFF);
		apb_write(REG_CARE, 64'h0000_000B);
		apb_write(REG_LEN, 64'd4);
		// short region
		push_byte(8'hDE, 1'b0);
		push_byte(8'hAD, 1'b1);
		// first match at 1, second one ignored
		push_byte(8'h11, 1'b0);
		push_byte(8'hDE, 1'b0);
		push_byte(8'hAD, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hEF, 1'b0);
		push_byte(8'hDE, 1'b0);
		push_byte(8'hAD, 1'b0);
		push_byte(8'hBE, 1'b0);
		push_byte(8'hEF, 1'b1);
		// match on the last byte
		push_byte(8'hDE, 1'b0);
		push_byte(8'hAD, 1'b0);
		push_byte(8'h77, 1'b0);
		push_byte(8'hEF, 1'b1);
		// no match
		push_byte(8'h12, 1'b0);
		push_byte(8'h34, 1'b0);
		push_byte(8'h56, 1'b0);
		push_byte(8'h78, 1'b0);
		push_byte(8'h9A, 1'b1);
		drain();

		// zero length acts as one
		apb_write(REG_CARE, 64'h1);
		apb_write(REG_LEN, 64'd0);
		push_byte(8'hDE, 1'b1);
		push_byte(8'h00, 1'b1);
		drain();

		for (ph = 0; ph < 10; ph++) begin
			byte_gap_max = (ph % 4 == 3) ? 0 : 8;
			res_stall_max = (ph % 4 == 1) ? 0 : 8;
			for (k = 0; k < 4; k++) begin
				case (ph)
					6: w = '1;
					7: w = '0;
					default: w = {$urandom, $urandom};
				endcase
				apb_write(reg_idx_t'(k), w);
			end
			case (ph)
				0, 1, 4: w = 64'hFFFF_FFFF;
				5: w = '0;
				default: w = {$urandom, $urandom};
			endcase
			apb_write(REG_CARE, w);
			case (ph)
				0: w = 64'd1;
				1: w = 64'd32;
				2: w = 64'd0;
				3: w = 64'd63;
				4: w = 64'd33;
				default: w = 64'($urandom_range(1, 32));
			endcase
			apb_write(REG_LEN, w);

			n = eff_len();
			total = 0;
			while (total < 75) begin
				mode = $urandom_range(0, 3);
				if ($urandom_range(0, 9) == 0)
					rl = $urandom_range(1, 64);
				else if (mode == 0)
					rl = $urandom_range(1, n + 8);
				else
					rl = $urandom_range(n, n + 8);
				for (k = 0; k < rl; k++)
					rb[k] = 8'($urandom_range(0, 255));
				if (mode != 0 && rl >= n) begin
					at = $urandom_range(0, rl - n);
					for (k = 0; k < n; k++)
						if (care_cfg[k])
							rb[at+k] = sig_cfg[k];
					if ($urandom_range(0, 4) == 0) begin
						k = $urandom_range(0, n - 1);
						rb[at+k] = rb[at+k] ^ 8'($urandom_range(1, 255));
					end
				end
				// the phase's last region may stay open across the settings change
				close = !(total + rl >= 75 && $urandom_range(0, 2) == 0);
				for (k = 0; k < rl; k++)
					push_byte(rb[k], (k == rl - 1) && close);
				total += rl;
			end
			drain();
		end

		if (n_err == 0)
			$display("tb_wildcard_byte_pattern_scanner_unit: clean");
		else
			$display("tb_wildcard_byte_pattern_scanner_unit: errors");
		$finish;
	end

endmodule
